// File: src/kffs_pkg.sv
`timescale 1ns / 1ps

package kffs_pkg;

	localparam int MS_W      = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

	// item kinds
	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_BYTE = 3'd1;
	localparam logic [2:0] KIND_K1   = 3'd2;
	localparam logic [2:0] KIND_K2   = 3'd3;
	localparam logic [2:0] KIND_K3   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd2;

	localparam logic [MS_W-1:0] LOCKOUT_RST    = 16'd1500;
	localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd3000;
	localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd50;

	// middle-button frame header
	localparam logic [7:0] HDR0 = 8'h57;
	localparam logic [7:0] HDR1 = 8'hAB;
	localparam logic [7:0] HDR2 = 8'h02;
	localparam int MID_BIT = 2;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       key_level;
	} in_item_t;

	typedef struct packed {
		logic       fwd_valid;
		logic [7:0] fwd_byte;
		logic       host_select;
		logic       middle_enabled;
		logic       led_enabled;
		logic       led_restart;
		logic       reset_request;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		logic host_select;
		logic middle_enabled;
		logic led_enabled;
		logic led_restart;
		logic reset_request;
	} status_t;

	typedef struct packed {
		logic    emit_frame;
		status_t status;
	} core_res_t;

endpackage

// File: src/kffs_core.sv
`timescale 1ns / 1ps

module kffs_core #(
	parameter int FRAME_BYTES = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [kffs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kffs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                commit,
	input  kffs_pkg::in_item_t                  item,
	output kffs_pkg::core_res_t                 res,
	output logic [FRAME_BYTES-1:0][7:0]         frame
);
	import kffs_pkg::*;

	localparam int FILL_W = $clog2(FRAME_BYTES);

	logic [MS_W-1:0]   lockout_q, long_press_q, debounce_q;
	logic [7:0]        store_q [FRAME_BYTES-1];
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              host_q, host_n;
	logic              middle_q, middle_n;
	logic              led_q, led_n;
	logic [MS_W-1:0]   since_q, since_n;
	logic              held_q, held_n;
	logic [MS_W-1:0]   hold_q, hold_n;
	logic              rflag_q, rflag_n;
	logic              restart, emit, last_byte, toggle_ok, mid_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q    <= LOCKOUT_RST;
			long_press_q <= LONG_PRESS_RST;
			debounce_q   <= DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LOCKOUT:    lockout_q    <= cfg_wdata;
				REG_LONG_PRESS: long_press_q <= cfg_wdata;
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// last byte of a frame comes straight from the item
	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_frame
		if (i == FRAME_BYTES - 1) begin : g_last
			assign frame[i] = item.data_byte;
		end else begin : g_st
			assign frame[i] = store_q[i];
			always_ff @(posedge clk) begin
				if (commit && item.kind == KIND_BYTE && fill_q == FILL_W'(i))
					store_q[i] <= item.data_byte;
			end
		end
	end

	assign toggle_ok = since_q > lockout_q;
	assign last_byte = fill_q == FILL_W'(FRAME_BYTES - 1);
	assign mid_frame = middle_q && frame[0] == HDR0 && frame[1] == HDR1 &&
		frame[2] == HDR2 && frame[3][MID_BIT];

	always_comb begin
		fill_n   = fill_q;
		host_n   = host_q;
		middle_n = middle_q;
		led_n    = led_q;
		since_n  = since_q;
		held_n   = held_q;
		hold_n   = hold_q;
		rflag_n  = rflag_q;
		restart  = 1'b0;
		emit     = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (since_q != MS_MAX)
					since_n = since_q + MS_W'(1);
				if (held_q) begin
					if (hold_q != MS_MAX)
						hold_n = hold_q + MS_W'(1);
					if (hold_n >= long_press_q)
						rflag_n = 1'b1;
				end
			end
			KIND_BYTE: begin
				if (last_byte) begin
					fill_n = '0;
					if (!mid_frame) begin
						emit = 1'b1;
					end else if (toggle_ok) begin
						// middle-button frame is dropped even when locked out
						since_n = '0;
						host_n  = !host_q;
						restart = 1'b1;
					end
				end else begin
					fill_n = fill_q + FILL_W'(1);
				end
			end
			KIND_K1: begin
				if (toggle_ok) begin
					since_n = '0;
					host_n  = !host_q;
					restart = 1'b1;
				end
			end
			KIND_K2: begin
				if (toggle_ok) begin
					since_n  = '0;
					middle_n = !middle_q;
				end
			end
			KIND_K3: begin
				if (!item.key_level) begin
					held_n = 1'b1;
					hold_n = '0;
				end else begin
					if (held_q && hold_q < long_press_q && hold_q > debounce_q && toggle_ok)
					begin
						since_n = '0;
						led_n   = !led_q;
						restart = !led_q;
					end
					held_n = 1'b0;
					hold_n = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			host_q   <= 1'b0;
			middle_q <= 1'b1;
			led_q    <= 1'b1;
			since_q  <= '0;
			held_q   <= 1'b0;
			hold_q   <= '0;
			rflag_q  <= 1'b0;
		end else if (commit) begin
			fill_q   <= fill_n;
			host_q   <= host_n;
			middle_q <= middle_n;
			led_q    <= led_n;
			since_q  <= since_n;
			held_q   <= held_n;
			hold_q   <= hold_n;
			rflag_q  <= rflag_n;
		end
	end

	assign res.emit_frame            = emit;
	assign res.status.host_select    = host_n;
	assign res.status.middle_enabled = middle_n;
	assign res.status.led_enabled    = led_n;
	assign res.status.led_restart    = restart;
	assign res.status.reset_request  = rflag_n;

endmodule

// File: src/kffs_burst.sv
`timescale 1ns / 1ps

module kffs_burst #(
	parameter int FRAME_BYTES = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  kffs_pkg::core_res_t         res,
	input  logic [FRAME_BYTES-1:0][7:0] frame,
	output logic                        free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output kffs_pkg::out_item_t         out_data
);
	import kffs_pkg::*;

	localparam int CNT_W = $clog2(FRAME_BYTES + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic [FRAME_BYTES-1:0][7:0] buf_q;
	status_t                     stat_q;
	logic                        fwdv_q;
	logic                        beat;

	assign out_valid = cnt_q != '0;
	assign beat      = out_valid && out_ready;
	assign free      = cnt_q == '0 || (cnt_q == CNT_W'(1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.emit_frame ? CNT_W'(FRAME_BYTES) : CNT_W'(1);
		end else if (beat) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= res.emit_frame ? frame : '0;
			fwdv_q <= res.emit_frame;
			stat_q <= res.status;
		end else if (beat) begin
			// shift the next frame byte to the head
			buf_q <= {8'd0, buf_q[FRAME_BYTES-1:1]};
		end
	end

	assign out_data.fwd_valid      = fwdv_q;
	assign out_data.fwd_byte       = buf_q[0];
	assign out_data.host_select    = stat_q.host_select;
	assign out_data.middle_enabled = stat_q.middle_enabled;
	assign out_data.led_enabled    = stat_q.led_enabled;
	assign out_data.led_restart    = stat_q.led_restart;
	assign out_data.reset_request  = stat_q.reset_request;
	assign out_data.last_result    = cnt_q == CNT_W'(1);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_BYTES))
		else $error("burst count beyond frame length");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.fwd_valid |-> out_data.last_result && out_data.fwd_byte == 8'd0)
		else $error("status beat not a single zero beat");

	a_burst_goes_on: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !out_data.last_result |=> out_valid && out_data.fwd_valid)
		else $error("frame burst broken off");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load && out_valid |-> out_data.last_result && out_ready)
		else $error("result loaded over a pending beat");

endmodule

// File: src/kvm_frame_filter_switch.sv
`timescale 1ns / 1ps
// items are registered in item_s1, then loaded into the output buffer behind out_valid
// throughput: one item per cycle with out_ready high; a frame burst is FRAME_BYTES beats
// the output buffer sets the pace: a new item is processed once its last beat drains
// reset: arst_n clears control and switch state to defaults (registers 1500/3000/50 ms)
// frame byte store has no reset and needs no clearing pass
module kvm_frame_filter_switch #(
	parameter int FRAME_BYTES = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [kffs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kffs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  kffs_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output kffs_pkg::out_item_t             out_data
);
	import kffs_pkg::*;

	in_item_t                    item_s1;
	logic                        v_s1;
	logic                        free, load;
	core_res_t                   res;
	logic [FRAME_BYTES-1:0][7:0] frame;

	assign load     = v_s1 && free;
	assign in_ready = !v_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	kffs_core #(.FRAME_BYTES(FRAME_BYTES)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.commit    (load),
		.item      (item_s1),
		.res       (res),
		.frame     (frame)
	);

	kffs_burst #(.FRAME_BYTES(FRAME_BYTES)) u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.frame     (frame),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
